// ===== design/stp_pkg.sv =====
// Shared types, constants and command codes for the trapezoid step generator.
`default_nettype none
package stp_pkg;
   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_MOVE = 3'd1;
   localparam logic [2:0] CMD_RUN  = 3'd2;
   localparam logic [2:0] CMD_STOP = 3'd3;
   localparam logic [2:0] CMD_ZERO = 3'd4;

   localparam logic [1:0] MODE_READY = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_MOVE  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_NULL = 2'd2;

   localparam logic [1:0] REG_MIN  = 2'd0;
   localparam logic [1:0] REG_CAP  = 2'd1;
   localparam logic [1:0] REG_STEP = 2'd2;
   localparam logic [1:0] REG_RATE = 2'd3;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== design/stp_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module stp_divider
   import stp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// ===== design/stepper_trapezoid_profile.sv =====
// Top level: trapezoidal ramp step generator with a sequenced planner.
// One beat is taken at a time. A tick or a command without planning work
// passes through the command, background and output states. Every divide
// (segment length and step period) goes through one shared bit-serial
// divider. A move costs one divide per walk level of the peak-speed planner
// plus up to four more for the first segment and the one planned after it.
// A run start takes up to four divides; other planning beats take up to two.
`default_nettype none
module stepper_trapezoid_profile
   import stp_pkg::*;
#(
   parameter int TICK_HZ = 62500
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // cmd[2:0], target_position[34:3], run_speed[50:35], run_dir[51], zero fill
   input  wire  [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // step_level[0], direction[1], mode[3:2], position[35:4],
   // speed_now[51:36], status[53:52], zero fill
   output logic [55:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   localparam logic [31:0] TickHz = 32'(TICK_HZ);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CMD    = 5'd1;
   localparam logic [4:0] S_WLEN   = 5'd2;
   localparam logic [4:0] S_WWAIT  = 5'd3;
   localparam logic [4:0] S_WSTEP  = 5'd4;
   localparam logic [4:0] S_WDONE  = 5'd5;
   localparam logic [4:0] S_PLAN   = 5'd6;
   localparam logic [4:0] S_PLWAIT = 5'd7;
   localparam logic [4:0] S_PERIOD = 5'd8;
   localparam logic [4:0] S_PEWAIT = 5'd9;
   localparam logic [4:0] S_PEDONE = 5'd10;
   localparam logic [4:0] S_BG     = 5'd11;
   localparam logic [4:0] S_OUT    = 5'd12;
   localparam logic [4:0] S_RLWAIT = 5'd13;

   // return targets after a period computation
   localparam logic [1:0] RET_START = 2'd0;
   localparam logic [1:0] RET_BG    = 2'd1;

   logic [4:0]  state_ff, state_in;
   logic [1:0]  ret_ff, ret_in;
   logic [15:0] min_ff, min_in, cap_ff, cap_in;
   logic [11:0] stp_ff, stp_in;
   logic [9:0]  rate_ff, rate_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [15:0] rspd_ff, rspd_in;
   logic        rdir_ff, rdir_in;
   logic [1:0]  mode_ff, mode_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in, sdone_ff, sdone_in, slen_ff, slen_in;
   logic [31:0] nlen_ff, nlen_in;
   logic [15:0] nspd_ff, nspd_in, peak_ff, peak_in;
   logic [31:0] decel_ff, decel_in, mdist_ff, mdist_in, splan_ff, splan_in;
   logic        upd_ff, upd_in, stopp_ff, stopp_in;
   logic [15:0] cper_ff, cper_in, nper_ff, nper_in, tcnt_ff, tcnt_in;
   logic        pulse_ff, pulse_in, dir_ff, dir_in;
   logic [15:0] goal_ff, goal_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] dist_ff, dist_in, acc_ff, acc_in;
   logic [15:0] wspd_ff, wspd_in;
   logic        outv_ff, outv_in;
   logic [55:0] outd_ff, outd_in;

   div_req_type dreq;
   div_rsp_type drsp;

   logic [15:0] est;
   logic [31:0] erate;
   logic [16:0] sum;
   logic [31:0] qlen;
   logic [15:0] qper;
   logic [31:0] diff, tdv;
   logic [16:0] tsum;
   logic [15:0] tc;
   logic [31:0] sd1;

   stp_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      est   = (stp_ff == '0) ? 16'd1 : {4'd0, stp_ff};
      erate = (rate_ff == '0) ? 32'd1 : {22'd0, rate_ff};
      qlen  = (drsp.quotient == '0) ? 32'd1 : drsp.quotient;
      qper  = (drsp.quotient > 32'hFFFF) ? 16'hFFFF : drsp.quotient[15:0];
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      min_in = min_ff; cap_in = cap_ff; stp_in = stp_ff; rate_in = rate_ff;
      cmd_in = cmd_ff; tgt_in = tgt_ff; rspd_in = rspd_ff; rdir_in = rdir_ff;
      mode_in = mode_ff; phase_in = phase_ff; pos_in = pos_ff;
      sdone_in = sdone_ff; slen_in = slen_ff; nlen_in = nlen_ff;
      nspd_in = nspd_ff; peak_in = peak_ff; decel_in = decel_ff;
      mdist_in = mdist_ff; splan_in = splan_ff; upd_in = upd_ff;
      stopp_in = stopp_ff; cper_in = cper_ff; nper_in = nper_ff;
      tcnt_in = tcnt_ff; pulse_in = pulse_ff; dir_in = dir_ff;
      goal_in = goal_ff; status_in = status_ff; dist_in = dist_ff;
      acc_in = acc_ff; wspd_in = wspd_ff;
      outv_in = outv_ff; outd_in = outd_ff;
      dreq.start = 1'b0; dreq.dividend = '0; dreq.divisor = erate;
      sum = '0; diff = '0; tdv = '0; tsum = '0; tc = '0; sd1 = '0;

      if (outv_ff && rsp_tready) outv_in = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            REG_MIN:  min_in  = csr_wdata;
            REG_CAP:  cap_in  = csr_wdata;
            REG_STEP: stp_in  = csr_wdata[11:0];
            REG_RATE: rate_in = csr_wdata[9:0];
            default:  ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = req_tdata[2:0];
               tgt_in  = req_tdata[34:3];
               rspd_in = req_tdata[50:35];
               rdir_in = req_tdata[51];
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            status_in = ST_OK;
            state_in  = S_BG;
            case (cmd_ff)
               CMD_TICK: begin
                  if (mode_ff != MODE_READY) begin
                     tc = tcnt_ff + 16'd1;
                     tcnt_in = tc;
                     if (tc >= cper_ff) begin
                        tcnt_in = '0;
                        if (pulse_ff) begin
                           pulse_in = 1'b0;
                           sd1 = sdone_ff + 32'd1;
                           sdone_in = sd1;
                           pos_in = dir_ff ? pos_ff - 32'd1 : pos_ff + 32'd1;
                           if (sd1 >= slen_ff) begin
                              if (upd_ff) begin
                                 cper_in = nper_ff;
                                 sdone_in = '0;
                                 slen_in = nlen_ff;
                                 upd_in = 1'b0;
                              end else if (stopp_ff) begin
                                 mode_in = MODE_READY;
                              end
                           end
                        end else begin
                           pulse_in = 1'b1;
                        end
                     end
                  end
               end
               CMD_MOVE: begin
                  diff = tgt_ff - pos_ff;
                  if (diff == '0) begin
                     status_in = ST_NULL;
                  end else begin
                     dir_in = diff[31];
                     if (diff[31]) diff = '0 - diff;
                     dist_in = diff; mdist_in = diff; acc_in = '0;
                     wspd_in = min_ff; peak_in = min_ff; phase_in = 3'd0;
                     state_in = S_WLEN;
                  end
               end
               CMD_RUN: begin
                  if (mode_ff == MODE_READY) begin
                     goal_in = rspd_ff; dir_in = rdir_ff; phase_in = 3'd0;
                     nspd_in = (min_ff > rspd_ff) ? rspd_ff : min_ff;
                     ret_in = RET_START;
                     state_in = S_PLAN;
                  end else begin
                     status_in = ST_BUSY;
                  end
               end
               CMD_STOP: mode_in = MODE_READY;
               CMD_ZERO: begin
                  if (mode_ff == MODE_READY) pos_in = '0;
                  else status_in = ST_BUSY;
               end
               default: ;
            endcase
         end
         S_WLEN: begin
            dreq.start = 1'b1; dreq.dividend = {16'd0, wspd_ff};
            state_in = S_WWAIT;
         end
         S_WWAIT: if (!drsp.busy) state_in = S_WSTEP;
         S_WSTEP: begin
            tdv = qlen;
            if ({2'b0, dist_ff} <= 34'(tdv) * 34'd3) begin
               state_in = S_WDONE;
            end else begin
               dist_in = dist_ff - {tdv[30:0], 1'b0};
               acc_in = acc_ff + tdv;
               tsum = {1'b0, wspd_ff} + {1'b0, est};
               wspd_in = tsum[16] ? 16'hFFFF : tsum[15:0];
               peak_in = wspd_in;
               if (wspd_in >= cap_ff || wspd_in == 16'hFFFF) state_in = S_WDONE;
               else state_in = S_WLEN;
            end
         end
         S_WDONE: begin
            decel_in = mdist_ff - acc_ff;
            // plan_next from phase zero
            splan_in = '0;
            nspd_in = min_ff;
            if (min_ff >= peak_ff) begin
               nlen_in = (decel_in == '0) ? 32'd1 : decel_in;
               phase_in = 3'd2;
               state_in = S_PERIOD;
            end else begin
               phase_in = 3'd1;
               state_in = S_PLAN;
            end
            ret_in = RET_START;
         end
         S_PLAN: begin
            dreq.start = 1'b1; dreq.dividend = {16'd0, nspd_ff};
            state_in = S_PLWAIT;
         end
         S_PLWAIT: if (!drsp.busy) begin
            nlen_in = qlen;
            state_in = S_PERIOD;
         end
         S_PERIOD: begin
            if (nspd_ff == '0) begin
               nper_in = 16'hFFFF;
               state_in = S_PEDONE;
            end else begin
               dreq.start = 1'b1; dreq.dividend = TickHz;
               dreq.divisor = {15'd0, nspd_ff, 1'b0};
               state_in = S_PEWAIT;
            end
         end
         S_PEWAIT: if (!drsp.busy) begin
            nper_in = qper;
            state_in = S_PEDONE;
         end
         S_PEDONE: begin
            unique case (ret_ff)
               RET_START: begin
                  sdone_in = '0; slen_in = nlen_ff; cper_in = nper_ff;
                  upd_in = 1'b0; stopp_in = 1'b0; tcnt_in = '0;
                  mode_in = (cmd_ff == CMD_RUN) ? MODE_RUN : MODE_MOVE;
                  state_in = S_BG;
               end
               RET_BG: begin
                  if (mode_ff == MODE_MOVE && phase_ff >= 3'd4) begin
                     stopp_in = 1'b1;
                     upd_in = (nlen_ff != '0);
                  end else begin
                     upd_in = 1'b1;
                  end
                  state_in = S_OUT;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_BG: begin
            state_in = S_OUT;
            if (!upd_ff) begin
               if (mode_ff == MODE_RUN) begin
                  if (nspd_ff < goal_ff) begin
                     sum = {1'b0, nspd_ff} + {1'b0, est};
                     nspd_in = sum[16] ? 16'hFFFF : sum[15:0];
                     if (nspd_in > goal_ff) nspd_in = goal_ff;
                     ret_in = RET_BG;
                     state_in = S_PLAN;
                  end
               end else if (mode_ff == MODE_MOVE) begin
                  if (nspd_ff == '0) begin
                     mode_in = MODE_READY;
                  end else if (phase_ff >= 3'd4) begin
                     stopp_in = 1'b1;
                  end else begin
                     ret_in = RET_BG;
                     splan_in = splan_ff + nlen_ff;
                     if (phase_ff == 3'd0) begin
                        splan_in = '0;
                        nspd_in = min_ff;
                        if (min_ff >= peak_ff) begin
                           nlen_in = (decel_ff == '0) ? 32'd1 : decel_ff;
                           phase_in = 3'd2;
                           state_in = S_PERIOD;
                        end else begin
                           phase_in = 3'd1;
                           state_in = S_PLAN;
                        end
                     end else if (phase_ff == 3'd1) begin
                        sum = {1'b0, nspd_ff} + {1'b0, est};
                        nspd_in = sum[16] ? 16'hFFFF : sum[15:0];
                        if (nspd_in >= peak_ff) begin
                           diff = (decel_ff > splan_in) ? decel_ff - splan_in : '0;
                           nlen_in = (diff == '0) ? 32'd1 : diff;
                           phase_in = 3'd2;
                           state_in = S_PERIOD;
                        end else begin
                           state_in = S_PLAN;
                        end
                     end else begin
                        sum = {1'b0, min_ff} + {1'b0, est};
                        if ({1'b0, nspd_ff} <= sum) begin
                           nspd_in = min_ff;
                           nlen_in = (mdist_ff > splan_in) ? mdist_ff - splan_in : '0;
                           phase_in = 3'd4;
                           state_in = S_PERIOD;
                        end else begin
                           nspd_in = nspd_ff - est;
                           phase_in = 3'd3;
                           state_in = S_PLAN;
                        end
                     end
                  end
               end
            end
         end
         S_OUT: begin
            if (!outv_ff || rsp_tready) begin
               outv_in = 1'b1;
               outd_in = {2'b0, status_ff, nspd_ff, pos_ff, mode_ff, dir_ff,
                          pulse_ff};
               state_in = S_IDLE;
            end
         end
         S_RLWAIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = outv_ff;
   assign rsp_tdata  = outd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= RET_START;
         min_ff <= 16'd200; cap_ff <= 16'd800; stp_ff <= 12'd20;
         rate_ff <= 10'd50; mode_ff <= MODE_READY; phase_ff <= '0;
         pos_ff <= '0; sdone_ff <= '0; slen_ff <= '0; nlen_ff <= '0;
         nspd_ff <= '0; peak_ff <= 16'd800; decel_ff <= '0; mdist_ff <= '0;
         splan_ff <= '0; upd_ff <= 1'b0; stopp_ff <= 1'b0; cper_ff <= '0;
         nper_ff <= '0; tcnt_ff <= '0; pulse_ff <= 1'b0; dir_ff <= 1'b0;
         goal_ff <= '0; outv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in;
         min_ff <= min_in; cap_ff <= cap_in; stp_ff <= stp_in;
         rate_ff <= rate_in; mode_ff <= mode_in; phase_ff <= phase_in;
         pos_ff <= pos_in; sdone_ff <= sdone_in; slen_ff <= slen_in;
         nlen_ff <= nlen_in; nspd_ff <= nspd_in; peak_ff <= peak_in;
         decel_ff <= decel_in; mdist_ff <= mdist_in; splan_ff <= splan_in;
         upd_ff <= upd_in; stopp_ff <= stopp_in; cper_ff <= cper_in;
         nper_ff <= nper_in; tcnt_ff <= tcnt_in; pulse_ff <= pulse_in;
         dir_ff <= dir_in; goal_ff <= goal_in; outv_ff <= outv_in;
      end
      cmd_ff <= cmd_in; tgt_ff <= tgt_in; rspd_ff <= rspd_in;
      rdir_ff <= rdir_in; status_ff <= status_in; dist_ff <= dist_in;
      acc_ff <= acc_in; wspd_ff <= wspd_in; outd_ff <= outd_in;
   end
endmodule
`default_nettype wire
